### src/cwr_pkg.sv
package cwr_pkg;

	// Field widths of the block.
	localparam int CW        = 20;
	localparam int GW        = 15;
	localparam int GAIN_FRAC = 14;

	// Derived datapath widths.
	localparam int DW   = CW + 1;          // offset pos - centre
	localparam int PRW  = 2 * CW + 2;      // products, dot product, squared length
	localparam int MAGW = 2 * CW + 1;      // magnitude of the dot product
	localparam int LOW  = DW;              // low slice of the dot magnitude
	localparam int HIW  = MAGW - LOW;      // high slice of the dot magnitude
	localparam int PLW  = DW + LOW;
	localparam int PHW  = DW + HIW;
	localparam int NW   = 3 * CW + 1;      // numerator |d| * |v.d|
	localparam int RW   = NW + 1;          // divider remainder
	localparam int QW   = CW + 1;          // quotient bits (|p| < 2^CW)
	localparam int TW   = CW + 2;          // tangential part
	localparam int MW   = TW + GW + 1;     // gain products

	// Pipeline depth.
	localparam int FRONT_ST = 6;
	localparam int BACK_ST  = 3;
	localparam int NST      = FRONT_ST + QW + BACK_ST;

	// Configuration register map.
	localparam int IDXW = 2;
	localparam logic [IDXW-1:0] REG_CENTRE_X    = 2'd0;
	localparam logic [IDXW-1:0] REG_CENTRE_Y    = 2'd1;
	localparam logic [IDXW-1:0] REG_TANGENT_GAIN = 2'd2;
	localparam logic [IDXW-1:0] REG_NORMAL_GAIN  = 2'd3;
	localparam logic [GW-1:0]   GAIN_RESET      = GW'(1 << GAIN_FRAC);

	typedef struct packed {
		logic [CW-1:0] centre_x;
		logic [CW-1:0] centre_y;
		logic [GW-1:0] tgain;
		logic [GW-1:0] ngain;
	} cwr_cfg_t;

	// Front end to divider.
	typedef struct packed {
		logic [NW-1:0]         num_x;
		logic [NW-1:0]         num_y;
		logic [PRW-1:0]        dd;
		logic signed [CW-1:0]  vel_x;
		logic signed [CW-1:0]  vel_y;
		logic                  neg_x;
		logic                  neg_y;
		logic                  at;
	} cwr_num_t;

	// Divider to back end.
	typedef struct packed {
		logic [QW-1:0]         q_x;
		logic [QW-1:0]         q_y;
		logic signed [CW-1:0]  vel_x;
		logic signed [CW-1:0]  vel_y;
		logic                  neg_x;
		logic                  neg_y;
		logic                  at;
	} cwr_quo_t;

	typedef struct packed {
		logic signed [CW-1:0] new_vel_x;
		logic signed [CW-1:0] new_vel_y;
		logic                 at_centre;
		logic                 clipped;
	} cwr_res_t;

endpackage

### src/cwr_if.sv
interface cwr_in_if;
	logic                         valid;
	logic                         ready;
	logic signed [cwr_pkg::CW-1:0] pos_x;
	logic signed [cwr_pkg::CW-1:0] pos_y;
	logic signed [cwr_pkg::CW-1:0] vel_x;
	logic signed [cwr_pkg::CW-1:0] vel_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface cwr_out_if;
	logic                         valid;
	logic                         ready;
	logic signed [cwr_pkg::CW-1:0] new_vel_x;
	logic signed [cwr_pkg::CW-1:0] new_vel_y;
	logic                         at_centre;
	logic                         clipped;

	modport source (output valid, new_vel_x, new_vel_y, at_centre, clipped, input ready);
	modport sink (input valid, new_vel_x, new_vel_y, at_centre, clipped, output ready);
endinterface

### src/circular_wall_reflection_top.sv
// Circular wall reflection: each item carries a body's position and velocity
// and returns the velocity after a bounce off a circle whose centre and gains
// sit in four write-only registers. The block is a 30-stage pipeline that
// takes one item every clock while its output is not held. The depth is set
// by the divider, which resolves one quotient bit per stage (21 stages), plus
// six front-end stages for the offset, dot product and numerator and three
// back-end stages for the gains and saturation. When a finished result is not
// taken, the whole pipeline holds; while the output stage is empty, a new item
// is always accepted.
module circular_wall_reflection_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [cwr_pkg::IDXW-1:0] cfg_index,
	input  logic [cwr_pkg::CW-1:0] cfg_data,
	cwr_in_if.sink                 in_ch,
	cwr_out_if.source              out_ch
);
	import cwr_pkg::*;

	cwr_cfg_t cfg_q;
	logic     en;
	logic     vld_q [NST];
	cwr_num_t num;
	cwr_quo_t quo;
	cwr_res_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_x <= '0;
			cfg_q.centre_y <= '0;
			cfg_q.tgain    <= GAIN_RESET;
			cfg_q.ngain    <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CENTRE_X:     cfg_q.centre_x <= cfg_data;
				REG_CENTRE_Y:     cfg_q.centre_y <= cfg_data;
				REG_TANGENT_GAIN: cfg_q.tgain    <= cfg_data[GW-1:0];
				REG_NORMAL_GAIN:  cfg_q.ngain    <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output stage is free or being taken.
	assign en = !vld_q[NST-1] || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_ch.valid;
			for (int i = 1; i < NST; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign in_ch.ready = en;

	cwr_front u_front (
		.clk   (clk),
		.en    (en),
		.pos_x (in_ch.pos_x),
		.pos_y (in_ch.pos_y),
		.vel_x (in_ch.vel_x),
		.vel_y (in_ch.vel_y),
		.cfg   (cfg_q),
		.num   (num)
	);

	cwr_div u_div (
		.clk (clk),
		.en  (en),
		.num (num),
		.quo (quo)
	);

	cwr_back u_back (
		.clk (clk),
		.en  (en),
		.quo (quo),
		.cfg (cfg_q),
		.res (res)
	);

	assign out_ch.valid     = vld_q[NST-1];
	assign out_ch.new_vel_x = res.new_vel_x;
	assign out_ch.new_vel_y = res.new_vel_y;
	assign out_ch.at_centre = res.at_centre;
	assign out_ch.clipped   = res.clipped;

endmodule

### src/cwr_front.sv
module cwr_front (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [cwr_pkg::CW-1:0] pos_x,
	input  logic signed [cwr_pkg::CW-1:0] pos_y,
	input  logic signed [cwr_pkg::CW-1:0] vel_x,
	input  logic signed [cwr_pkg::CW-1:0] vel_y,
	input  cwr_pkg::cwr_cfg_t             cfg,
	output cwr_pkg::cwr_num_t             num
);
	import cwr_pkg::*;

	logic signed [DW-1:0]  dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [CW-1:0]  vx_s1, vy_s1, vx_s2, vy_s2, vx_s3, vy_s3;
	logic signed [CW-1:0]  vx_s4, vy_s4, vx_s5, vy_s5, vx_s6, vy_s6;
	logic signed [PRW-1:0] vxdx_s2, vydy_s2, dxdx_s2, dydy_s2;
	logic signed [PRW-1:0] vd_s3;
	logic [PRW-1:0]        dd_s3, dd_s4, dd_s5, dd_s6;
	logic                  at_s2, at_s3, at_s4, at_s5, at_s6;
	logic [MAGW-1:0]       vmag_s4;
	logic [DW-1:0]         ax_s4, ay_s4;
	logic                  nx_s4, ny_s4, nx_s5, ny_s5, nx_s6, ny_s6;
	logic [PLW-1:0]        plx_s5, ply_s5;
	logic [PHW-1:0]        phx_s5, phy_s5;
	logic [NW-1:0]         numx_s6, numy_s6;
	logic                  vneg;

	// Offset from the circle centre.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {pos_x[CW-1], pos_x} - {cfg.centre_x[CW-1], cfg.centre_x};
			dy_s1 <= {pos_y[CW-1], pos_y} - {cfg.centre_y[CW-1], cfg.centre_y};
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;
		end
	end

	// Products for the dot product and the squared length.
	always_ff @(posedge clk) begin
		if (en) begin
			vxdx_s2 <= PRW'(vx_s1) * PRW'(dx_s1);
			vydy_s2 <= PRW'(vy_s1) * PRW'(dy_s1);
			dxdx_s2 <= PRW'(dx_s1) * PRW'(dx_s1);
			dydy_s2 <= PRW'(dy_s1) * PRW'(dy_s1);
			at_s2   <= (dx_s1 == '0) && (dy_s1 == '0);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			vx_s2   <= vx_s1;
			vy_s2   <= vy_s1;
		end
	end

	// Sums v.d and d.d.
	always_ff @(posedge clk) begin
		if (en) begin
			vd_s3 <= vxdx_s2 + vydy_s2;
			dd_s3 <= dxdx_s2 + dydy_s2;
			at_s3 <= at_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
		end
	end

	assign vneg = vd_s3[PRW-1];

	// Magnitudes and result signs of each projected component.
	always_ff @(posedge clk) begin
		if (en) begin
			vmag_s4 <= vneg ? MAGW'(-vd_s3) : MAGW'(vd_s3);
			ax_s4   <= dx_s3[DW-1] ? DW'(-dx_s3) : DW'(dx_s3);
			ay_s4   <= dy_s3[DW-1] ? DW'(-dy_s3) : DW'(dy_s3);
			nx_s4   <= dx_s3[DW-1] ^ vneg;
			ny_s4   <= dy_s3[DW-1] ^ vneg;
			dd_s4   <= dd_s3;
			at_s4   <= at_s3;
			vx_s4   <= vx_s3;
			vy_s4   <= vy_s3;
		end
	end

	// Numerator partial products, split on the dot magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			plx_s5 <= PLW'(ax_s4) * PLW'(vmag_s4[LOW-1:0]);
			phx_s5 <= PHW'(ax_s4) * PHW'(vmag_s4[MAGW-1:LOW]);
			ply_s5 <= PLW'(ay_s4) * PLW'(vmag_s4[LOW-1:0]);
			phy_s5 <= PHW'(ay_s4) * PHW'(vmag_s4[MAGW-1:LOW]);
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			dd_s5  <= dd_s4;
			at_s5  <= at_s4;
			vx_s5  <= vx_s4;
			vy_s5  <= vy_s4;
		end
	end

	// Numerator assembly.
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s6 <= NW'(plx_s5) + (NW'(phx_s5) << LOW);
			numy_s6 <= NW'(ply_s5) + (NW'(phy_s5) << LOW);
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			dd_s6   <= dd_s5;
			at_s6   <= at_s5;
			vx_s6   <= vx_s5;
			vy_s6   <= vy_s5;
		end
	end

	assign num.num_x = numx_s6;
	assign num.num_y = numy_s6;
	assign num.dd    = dd_s6;
	assign num.vel_x = vx_s6;
	assign num.vel_y = vy_s6;
	assign num.neg_x = nx_s6;
	assign num.neg_y = ny_s6;
	assign num.at    = at_s6;

endmodule

### src/cwr_div.sv
module cwr_div (
	input  logic              clk,
	input  logic              en,
	input  cwr_pkg::cwr_num_t num,
	output cwr_pkg::cwr_quo_t quo
);
	import cwr_pkg::*;

	typedef struct packed {
		logic [RW-1:0]        rem_x;
		logic [RW-1:0]        rem_y;
		logic [QW-1:0]        q_x;
		logic [QW-1:0]        q_y;
		logic [PRW-1:0]       dd;
		logic signed [CW-1:0] vel_x;
		logic signed [CW-1:0] vel_y;
		logic                 neg_x;
		logic                 neg_y;
		logic                 at;
	} cwr_dv_t;

	cwr_dv_t dv_s [QW];

	// One restoring quotient bit per stage, most significant first.
	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int SH = QW - 1 - k;
		cwr_dv_t       src;
		cwr_dv_t       nxt;
		logic [RW-1:0] dsh;

		if (k == 0) begin : g_head
			always_comb begin
				src       = '0;
				src.rem_x = RW'(num.num_x);
				src.rem_y = RW'(num.num_y);
				src.dd    = num.dd;
				src.vel_x = num.vel_x;
				src.vel_y = num.vel_y;
				src.neg_x = num.neg_x;
				src.neg_y = num.neg_y;
				src.at    = num.at;
			end
		end else begin : g_body
			assign src = dv_s[k-1];
		end

		always_comb begin
			nxt = src;
			dsh = RW'(src.dd) << SH;
			if (src.rem_x >= dsh) begin
				nxt.rem_x     = src.rem_x - dsh;
				nxt.q_x[SH]   = 1'b1;
			end
			if (src.rem_y >= dsh) begin
				nxt.rem_y     = src.rem_y - dsh;
				nxt.q_y[SH]   = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= nxt;
			end
		end
	end

	assign quo.q_x   = dv_s[QW-1].q_x;
	assign quo.q_y   = dv_s[QW-1].q_y;
	assign quo.vel_x = dv_s[QW-1].vel_x;
	assign quo.vel_y = dv_s[QW-1].vel_y;
	assign quo.neg_x = dv_s[QW-1].neg_x;
	assign quo.neg_y = dv_s[QW-1].neg_y;
	assign quo.at    = dv_s[QW-1].at;

endmodule

### src/cwr_back.sv
module cwr_back (
	input  logic              clk,
	input  logic              en,
	input  cwr_pkg::cwr_quo_t quo,
	input  cwr_pkg::cwr_cfg_t cfg,
	output cwr_pkg::cwr_res_t res
);
	import cwr_pkg::*;

	localparam logic signed [MW-1:0] SAT_HI   = (MW'(1) << (CW - 1)) - MW'(1);
	localparam logic signed [MW-1:0] SAT_LO   = ~SAT_HI;
	localparam logic signed [MW-1:0] GAIN_RND = (MW'(1) << GAIN_FRAC) - MW'(1);

	logic signed [QW-1:0] px_s1, py_s1;
	logic signed [TW-1:0] tx_s1, ty_s1;
	logic                 at_s1, at_s2;
	logic signed [MW-1:0] mtx_s2, mty_s2, mnx_s2, mny_s2;
	logic signed [MW-1:0] tg, ng;
	logic signed [QW-1:0] px, py;
	logic [CW:0]          sx, sy;
	cwr_res_t             res_s3;

	// Scale by the Q1.14 gain, truncating toward zero, and saturate.
	// The top bit of the result is the saturation flag.
	function automatic logic [CW:0] scale_sat(input logic signed [MW-1:0] r);
		logic signed [MW-1:0] rr;
		logic signed [MW-1:0] sh;
		rr = r[MW-1] ? r + GAIN_RND : r;
		sh = rr >>> GAIN_FRAC;
		if (sh > SAT_HI) begin
			scale_sat = {1'b1, SAT_HI[CW-1:0]};
		end else if (sh < SAT_LO) begin
			scale_sat = {1'b1, SAT_LO[CW-1:0]};
		end else begin
			scale_sat = {1'b0, sh[CW-1:0]};
		end
	endfunction

	// Signed normal part, zero when there is no normal.
	assign px = quo.at ? '0 : (quo.neg_x ? -quo.q_x : quo.q_x);
	assign py = quo.at ? '0 : (quo.neg_y ? -quo.q_y : quo.q_y);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px;
			py_s1 <= py;
			tx_s1 <= TW'(quo.vel_x) - TW'(px);
			ty_s1 <= TW'(quo.vel_y) - TW'(py);
			at_s1 <= quo.at;
		end
	end

	assign tg = MW'($signed({1'b0, cfg.tgain}));
	assign ng = MW'($signed({1'b0, cfg.ngain}));

	// Gain products.
	always_ff @(posedge clk) begin
		if (en) begin
			mtx_s2 <= MW'(tx_s1) * tg;
			mty_s2 <= MW'(ty_s1) * tg;
			mnx_s2 <= MW'(px_s1) * ng;
			mny_s2 <= MW'(py_s1) * ng;
			at_s2  <= at_s1;
		end
	end

	assign sx = scale_sat(mtx_s2 - mnx_s2);
	assign sy = scale_sat(mty_s2 - mny_s2);

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.new_vel_x <= sx[CW-1:0];
			res_s3.new_vel_y <= sy[CW-1:0];
			res_s3.at_centre <= at_s2;
			res_s3.clipped   <= sx[CW] | sy[CW];
		end
	end

	assign res = res_s3;

endmodule

### src/cwr_check.sv
module cwr_check (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [cwr_pkg::CW-1:0] nvx,
	input logic [cwr_pkg::CW-1:0] nvy,
	input logic                   clip
);
	import cwr_pkg::*;

	localparam logic [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

	// With no result waiting, the block must take an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while output stage is empty");

	// A clipped result sits on a bound in at least one component.
	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clip) |-> (nvx == VMAX || nvx == VMIN || nvy == VMAX || nvy == VMIN))
		else $error("clipped result not at a saturation bound");

	// A waiting result is not dropped.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(nvx) && $stable(nvy))
		else $error("stalled result changed");

	// No result is valid in the cycle after reset.
	a_no_out_after_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid right after reset");

endmodule

bind circular_wall_reflection_top cwr_check u_cwr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.nvx       (out_ch.new_vel_x),
	.nvy       (out_ch.new_vel_y),
	.clip      (out_ch.clipped)
);
